// ----- rtl/vnorm_pkg.sv -----
`timescale 1ns / 1ps

package vnorm_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int FRAC_BITS      = 14;
  localparam int LANES          = 4;
  localparam int SUM_W          = 2 * COMPONENT_BITS + 1;
  localparam int ROOT_W         = COMPONENT_BITS + 1;
  localparam int REM_W          = ROOT_W + 2;
  localparam int RAD_W          = 2 * ROOT_W;
  localparam int QUO_W          = FRAC_BITS + 1;
  localparam int DREM_W         = ROOT_W + 1;
  localparam int LEN_W          = 3;

  localparam logic [LEN_W-1:0]     LEN_MIN  = 3'd2;
  localparam logic [LEN_W-1:0]     LEN_MAX  = 3'd4;
  localparam logic [LEN_W-1:0]     LEN_RST  = 3'd4;
  localparam logic [QUO_W-1:0]     UNIT_ONE = 15'd16384;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] comp_x;
    logic signed [COMPONENT_BITS-1:0] comp_y;
    logic signed [COMPONENT_BITS-1:0] comp_z;
    logic signed [COMPONENT_BITS-1:0] comp_w;
  } in_item_t;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] unit_x;
    logic signed [COMPONENT_BITS-1:0] unit_y;
    logic signed [COMPONENT_BITS-1:0] unit_z;
    logic signed [COMPONENT_BITS-1:0] unit_w;
    logic                             was_zero;
  } out_item_t;

  // per-item data that rides along the root and divide pipes
  typedef struct packed {
    logic [LANES-1:0][COMPONENT_BITS-1:0] abs_val;
    logic [LANES-1:0]                     neg;
    logic [LANES-1:0]                     active;
  } side_t;

endpackage

// ----- rtl/vnorm_sqrt_pipe.sv -----
`timescale 1ns / 1ps

module vnorm_sqrt_pipe import vnorm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_sum,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output side_t             out_side
);

  logic              vld_r  [0:ROOT_W-1];
  logic [REM_W-1:0]  rem_r  [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_r [0:ROOT_W-1];
  logic [RAD_W-1:0]  rad_r  [0:ROOT_W-1];
  side_t             side_r [0:ROOT_W-1];

  logic [REM_W-1:0]  rem_nxt  [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_nxt [0:ROOT_W-1];
  logic [RAD_W-1:0]  rad_nxt  [0:ROOT_W-1];

  // one root bit per stage, radicand pairs from the top
  always_comb begin
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  shifted;
    logic [REM_W-1:0]  trial;
    for (int s = 0; s < ROOT_W; s++) begin
      if (s == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = {1'b0, in_sum};
      end else begin
        rem_in  = rem_r[s-1];
        root_in = root_r[s-1];
        rad_in  = rad_r[s-1];
      end
      shifted = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
      trial   = {root_in, 2'b01};
      rad_nxt[s] = {rad_in[RAD_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt[s]  = shifted - trial;
        root_nxt[s] = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[s]  = shifted;
        root_nxt[s] = {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ROOT_W; s++) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= (s == 0) ? in_valid : vld_r[s-1];
      end
      rem_r[s]  <= rem_nxt[s];
      root_r[s] <= root_nxt[s];
      rad_r[s]  <= rad_nxt[s];
      side_r[s] <= (s == 0) ? in_side : side_r[s-1];
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

// ----- rtl/vnorm_div_pipe.sv -----
`timescale 1ns / 1ps

module vnorm_div_pipe import vnorm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [ROOT_W-1:0]           in_root,
  input  side_t                       in_side,
  output logic                        out_valid,
  output logic [ROOT_W-1:0]           out_root,
  output side_t                       out_side,
  output logic [LANES-1:0][QUO_W-1:0] out_quo
);

  logic                        vld_r  [0:QUO_W-1];
  logic [ROOT_W-1:0]           root_r [0:QUO_W-1];
  side_t                       side_r [0:QUO_W-1];
  logic [LANES-1:0][DREM_W-1:0] rem_r [0:QUO_W-1];
  logic [LANES-1:0][QUO_W-1:0]  num_r [0:QUO_W-1];
  logic [LANES-1:0][QUO_W-1:0]  quo_r [0:QUO_W-1];

  logic [LANES-1:0][DREM_W-1:0] rem_nxt [0:QUO_W-1];
  logic [LANES-1:0][QUO_W-1:0]  num_nxt [0:QUO_W-1];
  logic [LANES-1:0][QUO_W-1:0]  quo_nxt [0:QUO_W-1];

  // (abs << 14) / root, one quotient bit per stage; an active lane's abs never exceeds
  // the root, so abs >> 1 is already below the divisor
  always_comb begin
    logic [DREM_W-1:0] rem_in;
    logic [QUO_W-1:0]  num_in;
    logic [QUO_W-1:0]  quo_in;
    logic [ROOT_W-1:0] dvs;
    logic [DREM_W-1:0] t;
    for (int s = 0; s < QUO_W; s++) begin
      for (int i = 0; i < LANES; i++) begin
        if (s == 0) begin
          rem_in = {3'b000, in_side.abs_val[i][COMPONENT_BITS-1:1]};
          num_in = {in_side.abs_val[i][0], {FRAC_BITS{1'b0}}};
          quo_in = '0;
          dvs    = in_root;
        end else begin
          rem_in = rem_r[s-1][i];
          num_in = num_r[s-1][i];
          quo_in = quo_r[s-1][i];
          dvs    = root_r[s-1];
        end
        t = {rem_in[DREM_W-2:0], num_in[QUO_W-1]};
        num_nxt[s][i] = {num_in[QUO_W-2:0], 1'b0};
        if (t >= {1'b0, dvs}) begin
          rem_nxt[s][i] = t - {1'b0, dvs};
          quo_nxt[s][i] = {quo_in[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[s][i] = t;
          quo_nxt[s][i] = {quo_in[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QUO_W; s++) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= (s == 0) ? in_valid : vld_r[s-1];
      end
      root_r[s] <= (s == 0) ? in_root : root_r[s-1];
      side_r[s] <= (s == 0) ? in_side : side_r[s-1];
      rem_r[s]  <= rem_nxt[s];
      num_r[s]  <= num_nxt[s];
      quo_r[s]  <= quo_nxt[s];
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_root  = root_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];
  assign out_quo   = quo_r[QUO_W-1];

endmodule

// ----- rtl/vector_normalize_unit.sv -----
`timescale 1ns / 1ps
// throughput: one transaction per cycle; busy stays low, a 17-stage root pipe and a
//   15-stage divide pipe each retire one bit per stage
// reset: synchronous active-low rst_n clears all valid bits and sets len_r to 4
// the receiver cannot stall: out_valid is a one-cycle strobe
module vector_normalize_unit import vnorm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  logic [LEN_W-1:0] len_r;
  logic             a_vld_r, b_vld_r, c_vld_r;
  side_t            a_side_r, b_side_r, c_side_r;
  logic [LANES-1:0][2*COMPONENT_BITS-1:0] b_sq_r;
  logic [SUM_W-1:0] c_sum_r;

  logic [LANES-1:0][COMPONENT_BITS-1:0] comp;
  side_t            a_side_nxt;
  logic [LEN_W-1:0] act_len;

  logic              s_vld;
  logic [ROOT_W-1:0] s_root;
  side_t             s_side;
  logic              d_vld;
  logic [ROOT_W-1:0] d_root;
  side_t             d_side;
  logic [LANES-1:0][QUO_W-1:0] d_quo;

  logic      o_vld_r;
  out_item_t o_data_r;
  out_item_t o_data_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      len_r <= cfg_data;
    end
  end

  assign comp = {in_data.comp_x, in_data.comp_y, in_data.comp_z, in_data.comp_w};

  always_comb begin
    if (len_r < LEN_MIN) begin
      act_len = LEN_MIN;
    end else if (len_r > LEN_MAX) begin
      act_len = LEN_MAX;
    end else begin
      act_len = len_r;
    end
    // packed lane 3 is x
    for (int i = 0; i < LANES; i++) begin
      a_side_nxt.neg[i]     = comp[i][COMPONENT_BITS-1];
      a_side_nxt.abs_val[i] = comp[i][COMPONENT_BITS-1] ? (~comp[i] + 1'b1) : comp[i];
      a_side_nxt.active[i]  = ((LANES - 1 - i) < int'(act_len));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
    a_side_r <= a_side_nxt;
    for (int i = 0; i < LANES; i++) begin
      b_sq_r[i] <= a_side_r.active[i] ? a_side_r.abs_val[i] * a_side_r.abs_val[i] : '0;
    end
    b_side_r <= a_side_r;
    c_sum_r  <= SUM_W'(b_sq_r[0]) + SUM_W'(b_sq_r[1]) + SUM_W'(b_sq_r[2])
              + SUM_W'(b_sq_r[3]);
    c_side_r <= b_side_r;
  end

  vnorm_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_vld_r),
    .in_sum    (c_sum_r),
    .in_side   (c_side_r),
    .out_valid (s_vld),
    .out_root  (s_root),
    .out_side  (s_side)
  );

  vnorm_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_vld),
    .in_root   (s_root),
    .in_side   (s_side),
    .out_valid (d_vld),
    .out_root  (d_root),
    .out_side  (d_side),
    .out_quo   (d_quo)
  );

  always_comb begin
    logic [LANES-1:0][COMPONENT_BITS-1:0] u;
    logic [QUO_W-1:0] q;
    logic             zero;
    zero = (d_root == '0);
    for (int i = 0; i < LANES; i++) begin
      q = (d_quo[i] > UNIT_ONE) ? UNIT_ONE : d_quo[i];
      if (!d_side.active[i] || zero) begin
        u[i] = '0;
      end else if (d_side.neg[i]) begin
        u[i] = COMPONENT_BITS'(~{1'b0, q} + 1'b1);
      end else begin
        u[i] = COMPONENT_BITS'(q);
      end
    end
    o_data_nxt.unit_x   = u[3];
    o_data_nxt.unit_y   = u[2];
    o_data_nxt.unit_z   = u[1];
    o_data_nxt.unit_w   = u[0];
    o_data_nxt.was_zero = zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= d_vld;
    end
    o_data_r <= o_data_nxt;
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_data_r;

endmodule
